// ----- rtl/crop_and_pixel_replicate_zoom_assert.svh -----
// ----------------------------------------------------------------------------
// crop and pixel replicate zoom assertion macros
// shorthand for clocked assertions with synchronous reset disable
// ----------------------------------------------------------------------------
`ifndef CROP_AND_PIXEL_REPLICATE_ZOOM_ASSERT_SVH
`define CROP_AND_PIXEL_REPLICATE_ZOOM_ASSERT_SVH

// same-cycle implication
`define CRPZ_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("crpz assertion failed");

// next-cycle implication
`define CRPZ_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("crpz assertion failed");

`endif

// ----- rtl/crpz_pkg.sv -----
// ----------------------------------------------------------------------------
// crpz_pkg
// shared widths, register indexes and controller/datapath interface types
// ----------------------------------------------------------------------------
package crpz_pkg;

  localparam int PIX_W      = 8;
  localparam int DEST_W     = 15;
  localparam int TOP_W      = 12;
  localparam int LEN_W      = 13;
  localparam int ZOOM_W     = 4;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 13;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CROP_TOP     = 3'd0,
    REG_CROP_LEFT    = 3'd1,
    REG_CROP_HEIGHT  = 3'd2,
    REG_CROP_WIDTH   = 3'd3,
    REG_ZOOM         = 3'd4,
    REG_SOURCE_WIDTH = 3'd5
  } reg_idx_t;

  typedef struct packed {
    logic [TOP_W-1:0]  crop_top;
    logic [TOP_W-1:0]  crop_left;
    logic [LEN_W-1:0]  crop_height;
    logic [LEN_W-1:0]  crop_width;
    logic [ZOOM_W-1:0] zoom;
    logic [LEN_W-1:0]  source_width;
  } cfg_t;

  typedef struct packed {
    logic capture;
    logic start;
    logic emit;
  } dp_cmd_t;

  typedef struct packed {
    logic in_window;
    logic out_free;
    logic block_end;
  } dp_status_t;

endpackage

// ----- rtl/crpz_cfg.sv -----
// ----------------------------------------------------------------------------
// crpz_cfg
// configuration register file with reset values
// ----------------------------------------------------------------------------
module crpz_cfg (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [crpz_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [crpz_pkg::CFG_DATA_W-1:0]    cfg_data,
  output crpz_pkg::cfg_t                     cfg
);
  import crpz_pkg::*;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.crop_top     <= '0;
      cfg.crop_left    <= '0;
      cfg.crop_height  <= LEN_W'(1);
      cfg.crop_width   <= LEN_W'(1);
      cfg.zoom         <= ZOOM_W'(1);
      cfg.source_width <= LEN_W'(1);
    end else if (cfg_valid && cfg_ready) begin
      unique case (reg_idx_t'(cfg_index))
        REG_CROP_TOP:     cfg.crop_top     <= cfg_data[TOP_W-1:0];
        REG_CROP_LEFT:    cfg.crop_left    <= cfg_data[TOP_W-1:0];
        REG_CROP_HEIGHT:  cfg.crop_height  <= cfg_data[LEN_W-1:0];
        REG_CROP_WIDTH:   cfg.crop_width   <= cfg_data[LEN_W-1:0];
        REG_ZOOM:         cfg.zoom         <= cfg_data[ZOOM_W-1:0];
        REG_SOURCE_WIDTH: cfg.source_width <= cfg_data[LEN_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

// ----- rtl/crpz_ctrl.sv -----
// ----------------------------------------------------------------------------
// crpz_ctrl
// sequencer: capture a pixel, check the window, emit its write block
// ----------------------------------------------------------------------------
module crpz_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  crpz_pkg::dp_status_t status,
  output crpz_pkg::dp_cmd_t    cmd
);
  import crpz_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_CHECK = 3'b010,
    S_EMIT  = 3'b100
  } state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_stall   = 1'b1;
    unique case (state)
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = S_CHECK;
        end
      end
      S_CHECK: begin
        if (status.in_window) begin
          cmd.start  = 1'b1;
          state_next = S_EMIT;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_EMIT: begin
        if (status.out_free) begin
          cmd.emit = 1'b1;
          if (status.block_end) begin
            state_next = S_IDLE;
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ----- rtl/crpz_dp.sv -----
// ----------------------------------------------------------------------------
// crpz_dp
// position counters, window test, base scaling and write register
// ----------------------------------------------------------------------------
module crpz_dp #(
  parameter int MAX_SIDE = 4096,
  parameter int MAX_ZOOM = 8
) (
  input  logic                            clk,
  input  logic                            rst,
  input  crpz_pkg::cfg_t                  cfg,
  input  crpz_pkg::dp_cmd_t               cmd,
  output crpz_pkg::dp_status_t            status,
  input  logic [crpz_pkg::PIX_W-1:0]      pixel,
  input  logic                            frame_start,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [crpz_pkg::DEST_W-1:0]     dest_row,
  output logic [crpz_pkg::DEST_W-1:0]     dest_col,
  output logic [crpz_pkg::PIX_W-1:0]      value,
  output logic                            block_last
);
  import crpz_pkg::*;

  localparam int PW = $clog2(MAX_SIDE);
  localparam int OW = $clog2(MAX_ZOOM);
  localparam int ZW = OW + 1;
  localparam int CW = ((PW > LEN_W) ? PW : LEN_W) + 1;
  localparam int NW = ((PW + 1) > LEN_W) ? (PW + 1) : LEN_W;
  localparam int XW = ((PW + ZW) > DEST_W) ? (PW + ZW) : DEST_W;

  logic [PW-1:0]     src_row;
  logic [PW-1:0]     src_col;
  logic [PW-1:0]     pos_row;
  logic [PW-1:0]     pos_col;
  logic [NW-1:0]     col_inc;
  logic              col_wrap;
  logic              row_wrap;
  logic [PIX_W-1:0]  pix;
  logic [CW-1:0]     row_diff;
  logic [CW-1:0]     col_diff;
  logic [OW-1:0]     zm1_c;
  logic [OW-1:0]     zm1;
  logic [ZW-1:0]     zoom_eff;
  logic [XW-1:0]     prod_row;
  logic [XW-1:0]     prod_col;
  logic [DEST_W-1:0] base_row;
  logic [DEST_W-1:0] base_col;
  logic [OW-1:0]     ro;
  logic [OW-1:0]     co;

  // position of the pixel being taken
  assign pos_row  = frame_start ? '0 : src_row;
  assign pos_col  = frame_start ? '0 : src_col;
  assign col_inc  = NW'(pos_col) + NW'(1);
  assign col_wrap = (pos_col == PW'(MAX_SIDE - 1)) || (col_inc >= NW'(cfg.source_width));
  assign row_wrap = (pos_row == PW'(MAX_SIDE - 1));

  // effective zoom minus one
  always_comb begin
    if (cfg.zoom == '0) begin
      zm1_c = '0;
    end else if (cfg.zoom > ZOOM_W'(MAX_ZOOM)) begin
      zm1_c = OW'(MAX_ZOOM - 1);
    end else begin
      zm1_c = OW'(cfg.zoom - ZOOM_W'(1));
    end
  end

  assign zoom_eff = ZW'(zm1_c) + ZW'(1);
  assign prod_row = XW'(row_diff[PW-1:0]) * XW'(zoom_eff);
  assign prod_col = XW'(col_diff[PW-1:0]) * XW'(zoom_eff);

  assign status.in_window = !row_diff[CW-1] && (row_diff < CW'(cfg.crop_height)) &&
                            !col_diff[CW-1] && (col_diff < CW'(cfg.crop_width));
  assign status.out_free  = !out_valid || !out_stall;
  assign status.block_end = (ro == zm1) && (co == zm1);

  // source counters
  always_ff @(posedge clk) begin
    if (rst) begin
      src_row <= '0;
      src_col <= '0;
    end else if (cmd.capture) begin
      if (col_wrap) begin
        src_col <= '0;
        src_row <= row_wrap ? '0 : PW'(pos_row + PW'(1));
      end else begin
        src_col <= col_inc[PW-1:0];
        src_row <= pos_row;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      pix      <= pixel;
      row_diff <= CW'(pos_row) - CW'(cfg.crop_top);
      col_diff <= CW'(pos_col) - CW'(cfg.crop_left);
    end
    if (cmd.start) begin
      zm1      <= zm1_c;
      base_row <= prod_row[DEST_W-1:0];
      base_col <= prod_col[DEST_W-1:0];
      ro       <= '0;
      co       <= '0;
    end else if (cmd.emit) begin
      if (ro == zm1) begin
        ro <= '0;
        co <= OW'(co + OW'(1));
      end else begin
        ro <= OW'(ro + OW'(1));
      end
    end
    if (cmd.emit) begin
      dest_row   <= base_row + DEST_W'(ro);
      dest_col   <= base_col + DEST_W'(co);
      value      <= pix;
      block_last <= status.block_end;
    end
  end

endmodule

// ----- rtl/crop_and_pixel_replicate_zoom.sv -----
// a kept pixel is captured in S_IDLE, tested in S_CHECK, and its writes are loaded in S_EMIT
// a new pixel is taken only in S_IDLE, after the previous one's check and its whole block are done
// the single write register emits one write per cycle while the output does not stall, which sets the block time
// the next pixel is taken while the last write of a block still waits at the output
// reset: synchronous, active high; clears source counters, sequencer and output valid,
// and returns every configuration register to its reset value
// ----------------------------------------------------------------------------
// crop_and_pixel_replicate_zoom
// crops a raster pixel stream to a window and replicates each kept pixel
// into a zoom-by-zoom block of destination writes
// ----------------------------------------------------------------------------
`include "crop_and_pixel_replicate_zoom_assert.svh"

module crop_and_pixel_replicate_zoom #(
  parameter int MAX_SIDE = 4096,
  parameter int MAX_ZOOM = 8
) (
  input  logic                            clk,
  input  logic                            rst,
  // source pixel channel
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [crpz_pkg::PIX_W-1:0]      pixel,
  input  logic                            frame_start,
  // destination write channel
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [crpz_pkg::DEST_W-1:0]     dest_row,
  output logic [crpz_pkg::DEST_W-1:0]     dest_col,
  output logic [crpz_pkg::PIX_W-1:0]      value,
  output logic                            block_last,
  // configuration write channel
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [crpz_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [crpz_pkg::CFG_DATA_W-1:0] cfg_data
);
  import crpz_pkg::*;

  cfg_t       cfg;
  dp_cmd_t    cmd;
  dp_status_t status;

  // register file: window, zoom and source row length
  crpz_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // sequencer: idle -> check window -> emit block
  crpz_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  // counters, window compare, base multiply and output register
  crpz_dp #(
    .MAX_SIDE (MAX_SIDE),
    .MAX_ZOOM (MAX_ZOOM)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .cmd         (cmd),
    .status      (status),
    .pixel       (pixel),
    .frame_start (frame_start),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .dest_row    (dest_row),
    .dest_col    (dest_col),
    .value       (value),
    .block_last  (block_last)
  );

  // one pixel in flight: a transfer is followed by a stall
  `CRPZ_ASSERT_NXT(a_one_pixel, in_valid && !in_stall, in_stall)
  // a write is only loaded when the output register is free
  `CRPZ_ASSERT_IMP(a_emit_free, cmd.emit, !out_valid || !out_stall)
  // a block only starts for a pixel inside the window
  `CRPZ_ASSERT_IMP(a_start_window, cmd.start, status.in_window)

endmodule

// ----- tb/zoom_write_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// zoom write checker
// follows the pixel, write and register channels, predicts the destination
// writes of every kept pixel and compares them in arrival order
// ----------------------------------------------------------------------------
module zoom_write_checker #(
  parameter int MAX_SIDE = 4096,
  parameter int MAX_ZOOM = 8
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  input  logic                            in_stall,
  input  logic [crpz_pkg::PIX_W-1:0]      pixel,
  input  logic                            frame_start,
  input  logic                            out_valid,
  input  logic                            out_stall,
  input  logic [crpz_pkg::DEST_W-1:0]     dest_row,
  input  logic [crpz_pkg::DEST_W-1:0]     dest_col,
  input  logic [crpz_pkg::PIX_W-1:0]      value,
  input  logic                            block_last,
  input  logic                            cfg_valid,
  input  logic                            cfg_ready,
  input  logic [crpz_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [crpz_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                              mismatches,
  output int                              pending,
  output int                              writes_seen
);

  localparam int PRINT_LIMIT = 30;

  typedef logic [crpz_pkg::DEST_W-1:0] coord_t;

  typedef struct packed {
    coord_t                      row;
    coord_t                      col;
    logic [crpz_pkg::PIX_W-1:0]  val;
    logic                        last;
  } dest_write_t;

  dest_write_t expected_writes[$];

  // window registers and source position, as the block should hold them
  int unsigned win_top, win_left, win_height, win_width, zoom_reg, src_width;
  int unsigned src_row, src_col;

  task automatic report_mismatch(input string msg);
    mismatches++;
    if (mismatches <= PRINT_LIMIT) $display("%0t ns: mismatch: %s", $time, msg);
  endtask

  task automatic clear_state();
    win_top     = 0;
    win_left    = 0;
    win_height  = 1;
    win_width   = 1;
    zoom_reg    = 1;
    src_width   = 1;
    src_row     = 0;
    src_col     = 0;
    mismatches  = 0;
    writes_seen = 0;
    expected_writes.delete();
  endtask

  task automatic apply_register(input logic [crpz_pkg::CFG_IDX_W-1:0] idx,
                                input logic [crpz_pkg::CFG_DATA_W-1:0] data);
    case (idx)
      crpz_pkg::REG_CROP_TOP:     win_top    = data[crpz_pkg::TOP_W-1:0];
      crpz_pkg::REG_CROP_LEFT:    win_left   = data[crpz_pkg::TOP_W-1:0];
      crpz_pkg::REG_CROP_HEIGHT:  win_height = data[crpz_pkg::LEN_W-1:0];
      crpz_pkg::REG_CROP_WIDTH:   win_width  = data[crpz_pkg::LEN_W-1:0];
      crpz_pkg::REG_ZOOM:         zoom_reg   = data[crpz_pkg::ZOOM_W-1:0];
      crpz_pkg::REG_SOURCE_WIDTH: src_width  = data[crpz_pkg::LEN_W-1:0];
      default: ;
    endcase
  endtask

  // queue the zoom-by-zoom block of a source pixel inside the window, then step the position
  task automatic replicate_pixel(input logic [crpz_pkg::PIX_W-1:0] pix, input logic fs);
    int unsigned z, r, c;
    dest_write_t w;
    if (fs) begin
      src_row = 0;
      src_col = 0;
    end
    if (src_row >= win_top && src_row - win_top < win_height &&
        src_col >= win_left && src_col - win_left < win_width) begin
      z = (zoom_reg == 0) ? 1 : ((zoom_reg > MAX_ZOOM) ? MAX_ZOOM : zoom_reg);
      r = src_row - win_top;
      c = src_col - win_left;
      for (int unsigned co = 0; co < z; co++) begin
        for (int unsigned ro = 0; ro < z; ro++) begin
          w.row  = coord_t'(r * z + ro);
          w.col  = coord_t'(c * z + co);
          w.val  = pix;
          w.last = (co + 1 == z) && (ro + 1 == z);
          expected_writes.push_back(w);
        end
      end
    end
    if (src_col + 1 >= src_width || src_col + 1 >= MAX_SIDE) begin
      src_col = 0;
      src_row = (src_row + 1 >= MAX_SIDE) ? 0 : src_row + 1;
    end else begin
      src_col = src_col + 1;
    end
  endtask

  always @(posedge clk) begin
    dest_write_t want;
    if (rst) begin
      clear_state();
    end else begin
      if (cfg_valid && cfg_ready) apply_register(cfg_index, cfg_data);
      if (in_valid && !in_stall) replicate_pixel(pixel, frame_start);
      if (out_valid && !out_stall) begin
        if (expected_writes.size() == 0) begin
          report_mismatch($sformatf("write %0d to row %0d col %0d with none expected",
                                    writes_seen, dest_row, dest_col));
        end else begin
          want = expected_writes.pop_front();
          if (dest_row !== want.row)
            report_mismatch($sformatf("write %0d dest_row %0d, expected %0d",
                                      writes_seen, dest_row, want.row));
          if (dest_col !== want.col)
            report_mismatch($sformatf("write %0d dest_col %0d, expected %0d",
                                      writes_seen, dest_col, want.col));
          if (value !== want.val)
            report_mismatch($sformatf("write %0d value %0d, expected %0d",
                                      writes_seen, value, want.val));
          if (block_last !== want.last)
            report_mismatch($sformatf("write %0d block_last %0b, expected %0b",
                                      writes_seen, block_last, want.last));
        end
        writes_seen++;
      end
    end
    pending = expected_writes.size();
  end

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crop and pixel replicate zoom testbench
// streams raster frames through the block under many window and zoom
// settings while both channels stall at random; the checker beside the
// block predicts every destination write and counts mismatches
// ----------------------------------------------------------------------------
module testbench;

  import crpz_pkg::*;

  localparam int CLK_HALF      = 10;
  localparam int RESET_CYCLES  = 8;
  // a pixel outside the window still occupies the block through S_CHECK
  localparam int SETTLE_CYCLES = 8;
  localparam int DRAIN_LIMIT   = 20000;
  localparam int RANDOM_PIXELS = 180;
  localparam int FULL_SIDE     = 4096;

  // indexes past the register map, the block must ignore writes to them
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

  typedef logic [CFG_DATA_W-1:0] cfg_word_t;
  typedef logic [PIX_W-1:0]      pix_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  pix_t                  pixel = '0;
  logic                  frame_start = 1'b0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [DEST_W-1:0]     dest_row;
  logic [DEST_W-1:0]     dest_col;
  pix_t                  value;
  logic                  block_last;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  cfg_word_t             cfg_data = '0;

  int mismatches, pending, writes_seen;

  // idle rates in percent, changed per phase
  int unsigned idle_pct  = 0;
  int unsigned stall_pct = 0;

  int unsigned pixels_sent      = 0;
  int unsigned settings_applied = 0;

  always #CLK_HALF clk = ~clk;

  crop_and_pixel_replicate_zoom i_dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .pixel       (pixel),
    .frame_start (frame_start),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .dest_row    (dest_row),
    .dest_col    (dest_col),
    .value       (value),
    .block_last  (block_last),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  zoom_write_checker i_checker (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .pixel       (pixel),
    .frame_start (frame_start),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .dest_row    (dest_row),
    .dest_col    (dest_col),
    .value       (value),
    .block_last  (block_last),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .mismatches  (mismatches),
    .pending     (pending),
    .writes_seen (writes_seen)
  );

  // single reset pulse at the start of the run
  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
  end

  // write side stalls at the rate of the current phase
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  // one pixel transfer; valid stays high afterwards so the next pixel can
  // follow back to back without a second assignment in the same step
  task automatic send_pixel(input pix_t pix, input logic fs);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    pixel       <= pix;
    frame_start <= fs;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pixels_sent++;
  endtask

  // source holds off until every predicted write has come out
  task automatic hold_until_drained();
    int unsigned spins;
    spins = 0;
    in_valid <= 1'b0;
    // let the checker book the last transfer before pending is read
    @(posedge clk);
    while (pending != 0 && spins < DRAIN_LIMIT) begin
      @(posedge clk);
      spins++;
    end
  endtask

  // idle point for register writes: drained, plus the tail of a pixel
  // that may still be in flight without producing anything
  task automatic settle();
    hold_until_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input cfg_word_t data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic program_window(input int unsigned top_row, left_col, height, width,
                                input int unsigned zoom_val, src_w);
    write_reg(REG_CROP_TOP, cfg_word_t'(top_row));
    write_reg(REG_CROP_LEFT, cfg_word_t'(left_col));
    // unmapped index now and then, must leave every register alone
    if ($urandom_range(2) == 0)
      write_reg($urandom_range(1) ? REG_SPARE_HI : REG_SPARE_LO, cfg_word_t'($urandom));
    write_reg(REG_CROP_HEIGHT, cfg_word_t'(height));
    write_reg(REG_CROP_WIDTH, cfg_word_t'(width));
    write_reg(REG_ZOOM, cfg_word_t'(zoom_val));
    write_reg(REG_SOURCE_WIDTH, cfg_word_t'(src_w));
    cfg_valid <= 1'b0;
    settings_applied++;
  endtask

  // raster frame of random pixels; a broken frame flips frame_start at random
  task automatic stream_frame(input int unsigned count, input bit broken);
    logic fs;
    for (int unsigned i = 0; i < count; i++) begin
      fs = (i == 0);
      if (broken && $urandom_range(7) == 0) fs = ~fs;
      if ($urandom_range(49) == 0) hold_until_drained();
      send_pixel(pix_t'($urandom), fs);
    end
  endtask

  // random window mostly around the source, now and then an extreme value
  task automatic random_setting(output int unsigned row_len);
    int unsigned top_row, left_col, height, width, zoom_val, src_w, pick;
    pick = $urandom_range(19);
    if (pick == 0) src_w = 0;
    else if (pick == 1) src_w = $urandom_range(FULL_SIDE, 8191);
    else src_w = $urandom_range(1, 10);
    // bit 12 lies above the 12-bit origin registers and must drop out
    top_row  = $urandom_range(3) | (($urandom_range(7) == 0) ? FULL_SIDE : 0);
    left_col = $urandom_range(6) | (($urandom_range(7) == 0) ? FULL_SIDE : 0);
    height   = ($urandom_range(9) == 0) ? $urandom_range(FULL_SIDE, 8191) : $urandom_range(5);
    width    = ($urandom_range(9) == 0) ? $urandom_range(FULL_SIDE, 8191) : $urandom_range(8);
    pick = $urandom_range(99);
    if (pick < 60) zoom_val = $urandom_range(1, 3);
    else if (pick < 85) zoom_val = $urandom_range(4, 8);
    else if (pick < 90) zoom_val = 0;
    else zoom_val = $urandom_range(9, 15);
    // junk above the 4-bit zoom field
    if ($urandom_range(9) == 0) zoom_val = zoom_val | ($urandom_range(1, 511) << 4);
    program_window(top_row, left_col, height, width, zoom_val, src_w);
    row_len = (src_w == 0) ? 1 : ((src_w > 12) ? 12 : src_w);
  endtask

  task automatic random_frames(input int unsigned quota);
    int unsigned sent_here, row_len, count;
    sent_here = 0;
    while (sent_here < quota) begin
      settle();
      random_setting(row_len);
      count = row_len * $urandom_range(1, 4);
      if (count > 40) count = 40;
      // mostly clean frames, about one in five broken
      stream_frame(count, $urandom_range(4) == 0);
      sent_here += count;
    end
  endtask

  task automatic directed_cases();
    // reset values: one-pixel window at the origin, zoom of one
    send_pixel(8'h00, 1'b1);
    send_pixel(8'hFF, 1'b0);
    settle();
    // full window at top zoom, extremes of the pixel value
    program_window(0, 0, FULL_SIDE, FULL_SIDE, 8, 4);
    send_pixel(8'h00, 1'b1);
    send_pixel(8'hFF, 1'b0);
    send_pixel(8'hAA, 1'b0);
    send_pixel(8'h55, 1'b0);
    settle();
    // zoom of zero behaves as one
    program_window(1, 1, 1, 1, 0, 2);
    for (int i = 0; i < 4; i++) send_pixel(pix_t'($urandom), i == 0);
    settle();
    // zoom above the maximum saturates
    program_window(0, 0, 2, 2, 15, 2);
    send_pixel(8'h81, 1'b1);
    send_pixel(8'h7E, 1'b0);
    settle();
    // empty window by height, then by width
    program_window(0, 0, 0, 4, 2, 4);
    send_pixel(8'h11, 1'b1);
    send_pixel(8'h22, 1'b0);
    settle();
    program_window(0, 0, 4, 0, 2, 4);
    send_pixel(8'h33, 1'b1);
    send_pixel(8'h44, 1'b0);
    settle();
    // source width of zero: every pixel closes its row, window clipped below
    program_window(0, 0, 3, 1, 2, 0);
    for (int i = 0; i < 4; i++) send_pixel(pix_t'($urandom), i == 0);
    settle();
    // frame start in mid-row restarts the counters
    program_window(0, 1, 2, 3, 2, 4);
    send_pixel(8'h01, 1'b1);
    send_pixel(8'h02, 1'b0);
    send_pixel(8'h03, 1'b1);
    send_pixel(8'h04, 1'b0);
  endtask

  initial begin
    wait (!rst);
    @(posedge clk);

    // sender rarely idles, receiver stalls often
    idle_pct  = 7;
    stall_pct = 47;
    directed_cases();
    random_frames(RANDOM_PIXELS / 3);

    // the other way round
    idle_pct  = 47;
    stall_pct = 7;
    random_frames(RANDOM_PIXELS / 3);

    // full rate on both sides
    idle_pct  = 0;
    stall_pct = 0;
    random_frames(RANDOM_PIXELS - 2 * (RANDOM_PIXELS / 3));

    settle();
    repeat (16) @(posedge clk);

    $display("ran %0d pixels over %0d window settings, directed corners included",
             pixels_sent, settings_applied);
    $display("compared %0d destination writes, %0d mismatches, %0d writes missing",
             writes_seen, mismatches, pending);
    if (mismatches == 0 && pending == 0) begin
      $display("crop_and_pixel_replicate_zoom regression: pass");
    end else begin
      $display("crop_and_pixel_replicate_zoom regression: fail");
    end
    $finish;
  end

  // hard stop, far beyond the slowest correct run
  initial begin
    #(20_000_000);
    $display("timeout with %0d writes still expected", pending);
    $display("crop_and_pixel_replicate_zoom regression: fail");
    $finish;
  end

endmodule

// ----- crop_and_pixel_replicate_zoom.f -----
+incdir+rtl
rtl/crpz_pkg.sv
rtl/crpz_cfg.sv
rtl/crpz_ctrl.sv
rtl/crpz_dp.sv
rtl/crop_and_pixel_replicate_zoom.sv
tb/zoom_write_checker.sv
tb/testbench.sv
